// File: rtl/mlsf_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// mlsf_pkg
// Shared types, codes and helpers for the misaligned load/store fixup block.
// ============================================================================
package mlsf_pkg;

    localparam logic [31:0] LIMIT_RESET = 32'hFFFF_FFFF;

    // Address space identifiers
    localparam logic [7:0] ASI_PRIMARY          = 8'h80;
    localparam logic [7:0] ASI_SECONDARY        = 8'h81;
    localparam logic [7:0] ASI_PRIMARY_LITTLE   = 8'h88;
    localparam logic [7:0] ASI_SECONDARY_LITTLE = 8'h89;

    // Result status codes
    localparam logic [1:0] STATUS_DONE        = 2'd0;
    localparam logic [1:0] STATUS_UNHANDLED   = 2'd1;
    localparam logic [1:0] STATUS_ADDR_FAULT  = 2'd2;

    // Register classes
    localparam logic [1:0] CLASS_INT = 2'd0;
    localparam logic [1:0] CLASS_FP  = 2'd1;
    localparam logic [1:0] CLASS_FSR = 2'd2;

    typedef enum logic [2:0] {
        SZ_1,
        SZ_2,
        SZ_4,
        SZ_8,
        SZ_16
    } t_size;

    typedef struct packed {
        logic [31:0] instruction;
        logic [31:0] base_value;
        logic [31:0] index_value;
        logic [7:0]  implicit_asi;
        logic [63:0] memory_first;
        logic [63:0] memory_second;
        logic [63:0] source_first;
        logic [63:0] source_second;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic        is_store;
        logic [4:0]  access_bytes;
        logic [31:0] effective_address;
        logic [4:0]  target_register;
        logic [1:0]  register_class;
        logic        pair_access;
        logic [63:0] load_first;
        logic [63:0] load_second;
        logic [63:0] store_first;
        logic [63:0] store_second;
    } t_result;

    // Decode results handed to the data steering logic
    typedef struct packed {
        logic [1:0] status;
        t_size      size;
        logic       is_store;
        logic       sign_ext;
        logic       little;
        logic       int_pair;
        logic       pair;
        logic [1:0] reg_class;
        logic [4:0] rd;
    } t_dec;

    function automatic logic [4:0] size_bytes(t_size s);
        logic [4:0] b;
        unique case (s)
            SZ_1:    b = 5'd1;
            SZ_2:    b = 5'd2;
            SZ_4:    b = 5'd4;
            SZ_8:    b = 5'd8;
            SZ_16:   b = 5'd16;
            default: b = 5'd0;
        endcase
        return b;
    endfunction

    function automatic logic [63:0] rev64(logic [63:0] x);
        logic [63:0] r;
        for (int i = 0; i < 8; i++) begin
            r[8*i +: 8] = x[8*(7-i) +: 8];
        end
        return r;
    endfunction

endpackage

// File: rtl/mlsf_decode.sv
`timescale 1ns / 1ps
// ============================================================================
// mlsf_decode
// Instruction decode, ASI check, address add and user limit compare.
// ============================================================================
module mlsf_decode
    import mlsf_pkg::*;
(
    input  logic [31:0] i_instruction,
    input  logic [31:0] i_base_value,
    input  logic [31:0] i_index_value,
    input  logic [7:0]  i_implicit_asi,
    input  logic [31:0] i_limit,
    output t_dec        o_dec,
    output logic [31:0] o_addr
);

    logic [5:0]  op3;
    logic [4:0]  rd;
    logic        fp;
    logic        imm;
    logic        fsr;
    logic        bad_op;
    logic        bad_asi;
    logic        little;
    logic [7:0]  asi;
    t_size       size;
    logic [31:0] offset;

    assign op3 = i_instruction[24:19];
    assign rd  = i_instruction[29:25];
    assign fp  = i_instruction[24];
    assign imm = i_instruction[13];
    assign fsr = fp && (op3[1:0] == 2'd1);

    always_comb begin
        bad_op = (i_instruction[31:30] != 2'b11) || ((op3[3:0] & 4'hd) == 4'hd);
        size   = SZ_4;
        if (fp) begin
            unique case (op3[1:0])
                2'd0: size = SZ_4;
                2'd1: size = (rd == 5'd0) ? SZ_4 : SZ_8;
                2'd2: size = SZ_16;
                2'd3: size = SZ_8;
                default: size = SZ_4;
            endcase
        end else begin
            unique case (op3[3:0])
                4'h0, 4'h4, 4'h8: size = SZ_4;
                4'h1, 4'h5, 4'h9: size = SZ_1;
                4'h2, 4'h6, 4'hA: size = SZ_2;
                4'h3, 4'h7, 4'hB, 4'hE: size = SZ_8;
                default: bad_op = 1'b1;
            endcase
        end
    end

    // alternate space forms carry an ASI
    always_comb begin
        asi     = imm ? i_implicit_asi : i_instruction[12:5];
        little  = 1'b0;
        bad_asi = 1'b0;
        if (op3[4]) begin
            if (asi == ASI_PRIMARY_LITTLE || asi == ASI_SECONDARY_LITTLE) begin
                little = 1'b1;
            end else if (asi != ASI_PRIMARY && asi != ASI_SECONDARY) begin
                bad_asi = 1'b1;
            end
        end
    end

    assign offset = imm ? {{19{i_instruction[12]}}, i_instruction[12:0]} : i_index_value;
    assign o_addr = i_base_value + offset;

    always_comb begin
        o_dec.size      = size;
        o_dec.is_store  = op3[2];
        o_dec.sign_ext  = op3[3];
        o_dec.little    = little;
        o_dec.int_pair  = !fp && (op3[1:0] == 2'd3) && !op3[3];
        o_dec.pair      = fp ? (size == SZ_16) : ((op3[1:0] == 2'd3) && !op3[3]);
        o_dec.reg_class = fsr ? CLASS_FSR : (fp ? CLASS_FP : CLASS_INT);
        // double/quad fp: odd rd folds into the upper bank
        o_dec.rd        = (fp && !fsr && (size == SZ_8 || size == SZ_16)) ?
                          {rd[0], rd[4:1]} : rd;
        if (bad_op || bad_asi) begin
            o_dec.status = STATUS_UNHANDLED;
        end else if (o_addr >= i_limit) begin
            o_dec.status = STATUS_ADDR_FAULT;
        end else begin
            o_dec.status = STATUS_DONE;
        end
    end

endmodule

// File: rtl/mlsf_steer.sv
`timescale 1ns / 1ps
// ============================================================================
// mlsf_steer
// Load extension and pair split, store byte image, little-endian swaps.
// ============================================================================
module mlsf_steer
    import mlsf_pkg::*;
(
    input  t_dec        i_dec,
    input  logic [63:0] i_memory_first,
    input  logic [63:0] i_memory_second,
    input  logic [63:0] i_source_first,
    input  logic [63:0] i_source_second,
    output logic [63:0] o_load_first,
    output logic [63:0] o_load_second,
    output logic [63:0] o_store_first,
    output logic [63:0] o_store_second
);

    logic [63:0] rm0, rm1, rs0, rs1;
    logic [63:0] m8;
    logic [63:0] pw;
    logic [31:0] m4;
    logic [15:0] m2;
    logic [7:0]  m1;
    logic        sx;

    assign rm0 = rev64(i_memory_first);
    assign rm1 = rev64(i_memory_second);
    assign rs0 = rev64(i_source_first);
    assign rs1 = rev64(i_source_second);
    assign pw  = i_dec.int_pair ? {i_source_first[31:0], i_source_second[31:0]}
                                : i_source_first;

    // top bytes of the first memory word, swapped for little-endian
    assign m8 = i_dec.little ? rm0 : i_memory_first;
    assign m4 = i_dec.little ? rm0[31:0] : i_memory_first[63:32];
    assign m2 = i_dec.little ? rm0[15:0] : i_memory_first[63:48];
    assign m1 = i_memory_first[63:56];
    assign sx = i_dec.sign_ext;

    always_comb begin
        o_load_first   = '0;
        o_load_second  = '0;
        o_store_first  = '0;
        o_store_second = '0;
        if (i_dec.is_store) begin
            unique case (i_dec.size)
                SZ_16: begin
                    o_store_first  = i_dec.little ? rs1 : i_source_first;
                    o_store_second = i_dec.little ? rs0 : i_source_second;
                end
                SZ_8: o_store_first = i_dec.little ? rev64(pw) : pw;
                SZ_4: o_store_first = {32'd0, i_dec.little ? rs0[63:32] : i_source_first[31:0]};
                SZ_2: o_store_first = {48'd0, i_dec.little ? rs0[63:48] : i_source_first[15:0]};
                SZ_1: o_store_first = {56'd0, i_source_first[7:0]};
                default: o_store_first = '0;
            endcase
        end else begin
            unique case (i_dec.size)
                SZ_16: begin
                    o_load_first  = i_dec.little ? rm1 : i_memory_first;
                    o_load_second = i_dec.little ? rm0 : i_memory_second;
                end
                SZ_8: begin
                    if (i_dec.int_pair) begin
                        o_load_first  = {32'd0, m8[63:32]};
                        o_load_second = {32'd0, m8[31:0]};
                    end else begin
                        o_load_first  = m8;
                    end
                end
                SZ_4: o_load_first = {{32{sx & m4[31]}}, m4};
                SZ_2: o_load_first = {{48{sx & m2[15]}}, m2};
                SZ_1: o_load_first = {{56{sx & m1[7]}}, m1};
                default: o_load_first = '0;
            endcase
        end
    end

endmodule

// File: rtl/misaligned_load_store_fixup_top.sv
`timescale 1ns / 1ps
// ============================================================================
// misaligned_load_store_fixup_top
// Emulates a trapping misaligned load or store: decode, address, data steering.
// ============================================================================
//
//  channel   | direction | handshake            | payload
//  ----------+-----------+----------------------+----------------------
//  item in   | in        | i_start, o_busy      | i_item   (t_in_item)
//  result    | out       | o_done (1-cycle)     | o_result (t_result)
//  config    | in        | i_cfg_we             | i_cfg_wdata (limit)
//
// Path: an accepted item goes through the input register, then through
// decode/add/compare/steer into the result register.
// One item per cycle sustained; the single combinational pass between the
// two registers sets the figure.
// Reset: synchronous, active low; clears the valid flags and sets the user
// address limit to all ones. o_busy is high only while reset is held.
// Stalls: none. The receiver takes every result on its strobe cycle.
//
module misaligned_load_store_fixup_top
    import mlsf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  t_in_item    i_item,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    output logic        o_done,
    output t_result     o_result
);

    logic        r_in_valid;
    t_in_item    r_item;
    logic        r_done;
    t_result     r_res;
    logic [31:0] r_limit;

    t_result     n_res;
    t_dec        dec;
    logic [31:0] addr;
    logic [63:0] lf, ls, sf, ss;

    // accept nothing while reset is held
    assign o_busy = !i_rst_n;

    // user limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !o_busy) begin
            r_item <= i_item;
        end
    end

    mlsf_decode u_decode (
        .i_instruction  (r_item.instruction),
        .i_base_value   (r_item.base_value),
        .i_index_value  (r_item.index_value),
        .i_implicit_asi (r_item.implicit_asi),
        .i_limit        (r_limit),
        .o_dec          (dec),
        .o_addr         (addr)
    );

    mlsf_steer u_steer (
        .i_dec           (dec),
        .i_memory_first  (r_item.memory_first),
        .i_memory_second (r_item.memory_second),
        .i_source_first  (r_item.source_first),
        .i_source_second (r_item.source_second),
        .o_load_first    (lf),
        .o_load_second   (ls),
        .o_store_first   (sf),
        .o_store_second  (ss)
    );

    // Result assembly: an unhandled item reports only its status; a fault
    // keeps the decode fields and the address but drops all data.
    always_comb begin
        n_res        = '0;
        n_res.status = dec.status;
        if (dec.status != STATUS_UNHANDLED) begin
            n_res.is_store          = dec.is_store;
            n_res.access_bytes      = size_bytes(dec.size);
            n_res.effective_address = addr;
            n_res.target_register   = dec.rd;
            n_res.register_class    = dec.reg_class;
            n_res.pair_access       = dec.pair;
        end
        if (dec.status == STATUS_DONE) begin
            n_res.load_first   = lf;
            n_res.load_second  = ls;
            n_res.store_first  = sf;
            n_res.store_second = ss;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_res <= n_res;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start, 2))
        else $error("result strobe without an item two cycles earlier");

    a_unhandled_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == STATUS_UNHANDLED) |->
        (o_result.access_bytes == 5'd0 && o_result.effective_address == 32'd0 &&
         o_result.load_first == 64'd0 && o_result.store_first == 64'd0))
        else $error("unhandled item carries nonzero fields");

    a_fault_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == STATUS_ADDR_FAULT) |->
        (o_result.load_first == 64'd0 && o_result.load_second == 64'd0 &&
         o_result.store_first == 64'd0 && o_result.store_second == 64'd0))
        else $error("faulting access carries data");

    a_load_no_store_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.is_store) |->
        (o_result.store_first == 64'd0 && o_result.store_second == 64'd0))
        else $error("load result carries store image");

    a_size_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status != STATUS_UNHANDLED) |->
        $onehot(o_result.access_bytes))
        else $error("access size not a power of two");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the misaligned load/store fixup block: directed
// decode corner cases, then random load/store traffic over several user limit
// settings, checked field by field against a local fixup predictor.
// ============================================================================
module testbench;
    import mlsf_pkg::*;

    // ------------------------------------------------------------------
    // Instruction encoding constants
    // ------------------------------------------------------------------
    localparam logic [1:0] OP_MEM   = 2'b11;   // load/store format
    localparam logic [1:0] OP_ARITH = 2'b10;   // anything else

    // Integer op3 low nibble
    localparam logic [3:0] NIB_LDUW = 4'h0;
    localparam logic [3:0] NIB_LDUB = 4'h1;
    localparam logic [3:0] NIB_LDUH = 4'h2;
    localparam logic [3:0] NIB_LDD  = 4'h3;
    localparam logic [3:0] NIB_STW  = 4'h4;
    localparam logic [3:0] NIB_STB  = 4'h5;
    localparam logic [3:0] NIB_STH  = 4'h6;
    localparam logic [3:0] NIB_STD  = 4'h7;
    localparam logic [3:0] NIB_LDSW = 4'h8;
    localparam logic [3:0] NIB_LDSB = 4'h9;
    localparam logic [3:0] NIB_LDSH = 4'ha;
    localparam logic [3:0] NIB_LDX  = 4'hb;
    localparam logic [3:0] NIB_BAD  = 4'hc;    // unhandled for integer class
    localparam logic [3:0] NIB_HOLE = 4'hd;    // unhandled for any class
    localparam logic [3:0] NIB_STX  = 4'he;
    localparam logic [3:0] NIB_LAST = 4'hf;    // unhandled for any class

    // Floating-point op3[1:0]
    localparam logic [1:0] FP_WORD   = 2'd0;
    localparam logic [1:0] FP_FSR    = 2'd1;
    localparam logic [1:0] FP_QUAD   = 2'd2;
    localparam logic [1:0] FP_DOUBLE = 2'd3;

    // Data fill for directed items
    localparam int FILL_RANDOM = 0;
    localparam int FILL_ZEROS  = 1;
    localparam int FILL_ONES   = 2;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_SLACK = 8;    // idle margin after the last result is seen

    // ------------------------------------------------------------------
    // DUT connections, all driven from time zero
    // ------------------------------------------------------------------
    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        start      = 1'b0;
    logic        busy;
    t_in_item    access_bus = '0;
    logic        cfg_we     = 1'b0;
    logic [31:0] cfg_wdata  = '0;
    logic        done;
    t_result     result;

    misaligned_load_store_fixup_top i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_item      (access_bus),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .o_done      (done),
        .o_result    (result)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    t_in_item    pending_accesses[$];   // filled by the stimulus block
    t_result     expected_fixups[$];    // predicted at acceptance
    logic [31:0] limit_model;           // bench copy of the user limit
    logic        item_on_port  = 1'b0;  // driver is presenting an item
    logic        last_taken    = 1'b0;  // item accepted at the last edge
    int unsigned sender_idle_pct = 0;
    int unsigned accesses_queued = 0;
    int unsigned fixups_seen     = 0;
    int unsigned mismatch_count  = 0;
    int unsigned cycle_count     = 0;

    // ------------------------------------------------------------------
    // Predictor helpers
    // ------------------------------------------------------------------
    // Reverse the low n bytes of x into the low n bytes of the result.
    function automatic logic [63:0] swap_bytes(logic [63:0] x, int unsigned n);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < n; i++) begin
            r = {r[55:0], x[7:0]};
            x = x >> 8;
        end
        return r;
    endfunction

    function automatic logic [63:0] byte_mask(int unsigned n);
        if (n >= 8) return '1;
        return (64'd1 << (8 * n)) - 64'd1;
    endfunction

    // Full decode, address, fault check and data steering for one access.
    function automatic t_result predict_fixup(t_in_item it, logic [31:0] limit);
        t_result     r;
        logic [5:0]  op3;
        logic [4:0]  rd;
        logic        fp, imm, st, sgn, fsr, pair, little;
        int unsigned sz;
        logic [1:0]  cls;
        logic [7:0]  asi;
        logic [31:0] addr;
        logic [63:0] w;
        r      = '0;
        op3    = it.instruction[24:19];
        rd     = it.instruction[29:25];
        fp     = it.instruction[24];
        imm    = it.instruction[13];
        st     = it.instruction[21];
        sgn    = it.instruction[22];
        fsr    = 1'b0;
        pair   = 1'b0;
        little = 1'b0;
        sz     = 0;
        cls    = CLASS_INT;

        // op field wrong, or low nibble 0xd / 0xf
        if (it.instruction[31:30] != OP_MEM || (op3[3] && op3[2] && op3[0])) begin
            r.status = STATUS_UNHANDLED;
            return r;
        end

        if (fp) begin
            case (op3[1:0])
                FP_WORD:   sz = 4;
                FP_FSR: begin
                    fsr = 1'b1;
                    sz  = (rd == 5'd0) ? 4 : 8;
                end
                FP_QUAD:   sz = 16;
                FP_DOUBLE: sz = 8;
            endcase
            cls = fsr ? CLASS_FSR : CLASS_FP;
            // double/quad register numbering: odd rd maps to the upper bank
            if (sz > 4 && !fsr) rd = {rd[0], rd[4:1]};
            pair = (sz == 16);
        end else begin
            case (op3[3:0])
                NIB_LDUW, NIB_STW, NIB_LDSW: sz = 4;
                NIB_LDUB, NIB_STB, NIB_LDSB: sz = 1;
                NIB_LDUH, NIB_STH, NIB_LDSH: sz = 2;
                NIB_LDD, NIB_STD: begin
                    sz   = 8;
                    pair = 1'b1;
                end
                NIB_LDX, NIB_STX: sz = 8;
                default: begin
                    r.status = STATUS_UNHANDLED;
                    return r;
                end
            endcase
        end

        // alternate space: immediate form takes the ASI from trap state
        if (op3[4]) begin
            asi = imm ? it.implicit_asi : it.instruction[12:5];
            if (asi == ASI_PRIMARY_LITTLE || asi == ASI_SECONDARY_LITTLE) begin
                little = 1'b1;
            end else if (asi != ASI_PRIMARY && asi != ASI_SECONDARY) begin
                r.status = STATUS_UNHANDLED;
                return r;
            end
        end

        addr = it.base_value + (imm ? {{19{it.instruction[12]}}, it.instruction[12:0]}
                                    : it.index_value);

        r.is_store          = st;
        r.access_bytes      = 5'(sz);
        r.effective_address = addr;
        r.target_register   = rd;
        r.register_class    = cls;
        r.pair_access       = pair;

        if (addr >= limit) begin
            r.status = STATUS_ADDR_FAULT;
            return r;
        end
        r.status = STATUS_DONE;

        if (st) begin
            if (sz == 16) begin
                r.store_first  = little ? swap_bytes(it.source_second, 8) : it.source_first;
                r.store_second = little ? swap_bytes(it.source_first, 8) : it.source_second;
            end else begin
                // integer pair packs the two low words
                w = (pair && !fp) ? {it.source_first[31:0], it.source_second[31:0]}
                                  : it.source_first;
                w = w & byte_mask(sz);
                r.store_first = little ? swap_bytes(w, sz) : w;
            end
        end else begin
            if (sz == 16) begin
                r.load_first  = little ? swap_bytes(it.memory_second, 8) : it.memory_first;
                r.load_second = little ? swap_bytes(it.memory_first, 8) : it.memory_second;
            end else if (sz == 8) begin
                w = little ? swap_bytes(it.memory_first, 8) : it.memory_first;
                if (pair && !fp) begin
                    r.load_first  = {32'd0, w[63:32]};
                    r.load_second = {32'd0, w[31:0]};
                end else begin
                    r.load_first = w;
                end
            end else begin
                // leading bytes of memory, then endian swap, then extension
                w = it.memory_first >> (64 - 8 * sz);
                if (little) w = swap_bytes(w, sz);
                if (sgn && w[8 * sz - 1]) w = w | ~byte_mask(sz);
                r.load_first = w;
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [31:0] make_insn(logic [1:0] op, logic [4:0] rd,
                                              logic [5:0] op3, logic imm,
                                              logic [12:0] low13);
        return {op, rd, op3, 5'd0, imm, low13};
    endfunction

    function automatic logic [7:0] pick_good_asi();
        case ($urandom_range(3))
            0:       return ASI_PRIMARY;
            1:       return ASI_SECONDARY;
            2:       return ASI_PRIMARY_LITTLE;
            default: return ASI_SECONDARY_LITTLE;
        endcase
    endfunction

    // Mostly well-formed accesses, about a tenth unhandled noise; a fifth of
    // the addresses are steered to straddle the current user limit.
    function automatic t_in_item random_access(logic [31:0] lim);
        t_in_item    it;
        logic [3:0]  nib;
        logic        fp, alt, imm;
        logic [4:0]  rd;
        logic [7:0]  asi;
        logic [12:0] simm;
        logic [31:0] offset;
        logic [31:0] target;
        int unsigned pick;
        it.memory_first  = {$urandom, $urandom};
        it.memory_second = {$urandom, $urandom};
        it.source_first  = {$urandom, $urandom};
        it.source_second = {$urandom, $urandom};
        pick = $urandom_range(99);
        fp   = (pick >= 45);
        if (fp) begin
            do nib = 4'($urandom_range(15));
            while (nib == NIB_HOLE || nib == NIB_LAST);
        end else begin
            do nib = 4'($urandom_range(15));
            while (nib == NIB_BAD || nib == NIB_HOLE || nib == NIB_LAST);
        end
        alt = 1'($urandom_range(1));
        imm = 1'($urandom_range(1));
        rd  = 5'($urandom);
        case ($urandom_range(9))
            0:       simm = 13'h1000;
            1:       simm = 13'h0fff;
            default: simm = 13'($urandom);
        endcase
        asi = ($urandom_range(9) == 0) ? 8'($urandom) : pick_good_asi();
        if (imm) begin
            it.instruction  = make_insn(OP_MEM, rd, {fp, alt, nib}, 1'b1, simm);
            it.implicit_asi = asi;
        end else begin
            it.instruction  = make_insn(OP_MEM, rd, {fp, alt, nib}, 1'b0,
                                        {asi, 5'($urandom)});
            it.implicit_asi = 8'($urandom);
        end
        it.instruction[18:14] = 5'($urandom);
        it.base_value  = $urandom;
        it.index_value = $urandom;
        case ($urandom_range(9))
            0: begin
                it.base_value  = '1;
                it.index_value = '1;
            end
            1: begin
                it.base_value  = '0;
                it.index_value = '0;
            end
            2, 3: begin
                offset = imm ? {{19{simm[12]}}, simm} : it.index_value;
                target = lim + 32'($urandom_range(3)) - 32'd2;
                it.base_value = target - offset;
            end
            default: ;
        endcase
        if (pick >= 90) begin
            case ($urandom_range(2))
                0: it.instruction = $urandom;
                1: it.instruction[22:19] = $urandom_range(1) ? NIB_HOLE : NIB_LAST;
                default: begin
                    it.instruction[24]    = 1'b0;
                    it.instruction[22:19] = NIB_BAD;
                end
            endcase
        end
        return it;
    endfunction

    task automatic queue_access(t_in_item it);
        pending_accesses.push_back(it);
        accesses_queued++;
    endtask

    task automatic queue_directed(logic [31:0] insn, logic [31:0] base,
                                  logic [31:0] index, logic [7:0] iasi, int fill);
        t_in_item it;
        it.instruction  = insn;
        it.base_value   = base;
        it.index_value  = index;
        it.implicit_asi = iasi;
        case (fill)
            FILL_ZEROS: begin
                it.memory_first  = '0;
                it.memory_second = '0;
                it.source_first  = '0;
                it.source_second = '0;
            end
            FILL_ONES: begin
                it.memory_first  = '1;
                it.memory_second = '1;
                it.source_first  = '1;
                it.source_second = '1;
            end
            default: begin
                it.memory_first  = {$urandom, $urandom};
                it.memory_second = {$urandom, $urandom};
                it.source_first  = {$urandom, $urandom};
                it.source_second = {$urandom, $urandom};
            end
        endcase
        queue_access(it);
    endtask

    // Limit writes happen only with the block drained.
    task automatic write_limit(logic [31:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Hold the sender until every queued item has produced its result.
    task automatic drain();
        while (fixups_seen < accesses_queued) @(negedge clk);
        repeat (DRAIN_SLACK) @(negedge clk);
    endtask

    task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch %s: expected %h, got %h", name, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: presents the next pending item at the falling edge. An item
    // stays on the port until an edge with start high and busy low takes it.
    // ------------------------------------------------------------------
    always @(negedge clk) begin : driver
        logic     present;
        t_in_item next_item;
        present   = item_on_port;
        next_item = access_bus;
        if (present && last_taken) present = 1'b0;
        if (!present && pending_accesses.size() > 0 &&
            $urandom_range(99) >= sender_idle_pct) begin
            next_item = pending_accesses.pop_front();
            present   = 1'b1;
        end
        item_on_port <= present;
        start        <= present;
        access_bus   <= next_item;
    end

    // ------------------------------------------------------------------
    // Monitor: predicts on acceptance, checks each result strobe against the
    // oldest prediction, and tracks limit writes.
    // ------------------------------------------------------------------
    always @(posedge clk) begin : monitor
        t_result want;
        if (!rst_n) begin
            limit_model = LIMIT_RESET;
            last_taken <= 1'b0;
        end else begin
            if (done === 1'b1) begin
                fixups_seen++;
                if (expected_fixups.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: %p", result);
                end else begin
                    want = expected_fixups.pop_front();
                    compare_field("status", 64'(want.status), 64'(result.status));
                    compare_field("is_store", 64'(want.is_store), 64'(result.is_store));
                    compare_field("access_bytes", 64'(want.access_bytes),
                                  64'(result.access_bytes));
                    compare_field("effective_address", 64'(want.effective_address),
                                  64'(result.effective_address));
                    compare_field("target_register", 64'(want.target_register),
                                  64'(result.target_register));
                    compare_field("register_class", 64'(want.register_class),
                                  64'(result.register_class));
                    compare_field("pair_access", 64'(want.pair_access),
                                  64'(result.pair_access));
                    compare_field("load_first", want.load_first, result.load_first);
                    compare_field("load_second", want.load_second, result.load_second);
                    compare_field("store_first", want.store_first, result.store_first);
                    compare_field("store_second", want.store_second, result.store_second);
                end
            end
            last_taken <= start && !busy;
            if (start && !busy)
                expected_fixups.push_back(predict_fixup(access_bus, limit_model));
            if (cfg_we) limit_model = cfg_wdata;
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    logic [31:0] phase_limit [5];
    int unsigned phase_idle  [5];
    int unsigned phase_count [5];

    initial begin : stimulus
        logic [31:0] lim;
        phase_limit = '{32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0000, $urandom,
                        32'h0001_0000};
        phase_idle  = '{0, 71, 28, 0, 71};
        phase_count = '{140, 140, 50, 120, 80};

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners with the reset limit
        sender_idle_pct = 0;
        // most negative displacement from a zero base wraps the address
        queue_directed(make_insn(OP_MEM, 5'd1, {2'b00, NIB_LDUW}, 1'b1, 13'h1000),
                       32'h0, 32'h0, 8'h00, FILL_RANDOM);
        queue_directed(make_insn(OP_MEM, 5'd2, {2'b00, NIB_LDUB}, 1'b0, 13'h0),
                       32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, FILL_ONES);
        // sign extension of each short size
        queue_directed(make_insn(OP_MEM, 5'd3, {2'b00, NIB_LDSB}, 1'b1, 13'h0fff),
                       32'h100, 32'h0, 8'h00, FILL_ONES);
        queue_directed(make_insn(OP_MEM, 5'd4, {2'b00, NIB_LDSH}, 1'b1, 13'h0002),
                       32'h100, 32'h0, 8'h00, FILL_ONES);
        queue_directed(make_insn(OP_MEM, 5'd5, {2'b00, NIB_LDSW}, 1'b1, 13'h0003),
                       32'h100, 32'h0, 8'h00, FILL_ZEROS);
        // integer pairs and extended words
        queue_directed(make_insn(OP_MEM, 5'd31, {2'b00, NIB_LDD}, 1'b0, 13'h0),
                       32'h1234, 32'h5, 8'h00, FILL_RANDOM);
        queue_directed(make_insn(OP_MEM, 5'd0, {2'b00, NIB_STD}, 1'b0, 13'h0),
                       32'h1234, 32'h6, 8'h00, FILL_RANDOM);
        queue_directed(make_insn(OP_MEM, 5'd7, {2'b00, NIB_LDX}, 1'b1, 13'h0001),
                       32'h4000, 32'h0, 8'h00, FILL_RANDOM);
        queue_directed(make_insn(OP_MEM, 5'd8, {2'b00, NIB_STX}, 1'b1, 13'h0003),
                       32'h4000, 32'h0, 8'h00, FILL_ONES);
        queue_directed(make_insn(OP_MEM, 5'd9, {2'b00, NIB_STB}, 1'b1, 13'h0001),
                       32'h4000, 32'h0, 8'h00, FILL_RANDOM);
        queue_directed(make_insn(OP_MEM, 5'd10, {2'b00, NIB_STH}, 1'b1, 13'h0001),
                       32'h4000, 32'h0, 8'h00, FILL_RANDOM);
        queue_directed(make_insn(OP_MEM, 5'd11, {2'b00, NIB_STW}, 1'b1, 13'h0002),
                       32'h4000, 32'h0, 8'h00, FILL_RANDOM);
        // alternate spaces: register-form ASI and trap-state ASI, both endians
        queue_directed(make_insn(OP_MEM, 5'd12, {2'b01, NIB_LDUW}, 1'b0,
                                 {ASI_PRIMARY_LITTLE, 5'd0}),
                       32'h2000, 32'h1, 8'h00, FILL_RANDOM);
        queue_directed(make_insn(OP_MEM, 5'd13, {2'b01, NIB_LDSH}, 1'b1, 13'h0001),
                       32'h2000, 32'h0, ASI_SECONDARY_LITTLE, FILL_ONES);
        queue_directed(make_insn(OP_MEM, 5'd14, {2'b01, NIB_STD}, 1'b0,
                                 {ASI_SECONDARY_LITTLE, 5'd0}),
                       32'h2000, 32'h2, 8'h00, FILL_RANDOM);
        queue_directed(make_insn(OP_MEM, 5'd15, {2'b01, NIB_LDD}, 1'b1, 13'h0004),
                       32'h2000, 32'h0, ASI_SECONDARY, FILL_RANDOM);
        // floating point: word, odd double, little quad load and store, FSR
        queue_directed(make_insn(OP_MEM, 5'd16, {2'b10, 2'b00, FP_WORD}, 1'b1, 13'h1),
                       32'h3000, 32'h0, 8'h00, FILL_RANDOM);
        queue_directed(make_insn(OP_MEM, 5'd31, {2'b10, 2'b00, FP_DOUBLE}, 1'b1, 13'h4),
                       32'h3000, 32'h0, 8'h00, FILL_RANDOM);
        queue_directed(make_insn(OP_MEM, 5'd3, {2'b11, 2'b00, FP_QUAD}, 1'b1, 13'h8),
                       32'h3000, 32'h0, ASI_PRIMARY_LITTLE, FILL_RANDOM);
        queue_directed(make_insn(OP_MEM, 5'd6, {2'b11, 2'b01, FP_QUAD}, 1'b0,
                                 {ASI_SECONDARY_LITTLE, 5'd0}),
                       32'h3000, 32'h4, 8'h00, FILL_RANDOM);
        queue_directed(make_insn(OP_MEM, 5'd0, {2'b10, 2'b00, FP_FSR}, 1'b1, 13'h2),
                       32'h3000, 32'h0, 8'h00, FILL_RANDOM);
        queue_directed(make_insn(OP_MEM, 5'd1, {2'b10, 2'b01, FP_FSR}, 1'b1, 13'h2),
                       32'h3000, 32'h0, 8'h00, FILL_RANDOM);
        // unhandled: wrong op, hole nibble, integer nibble 0xc, bad ASI
        queue_directed(make_insn(OP_ARITH, 5'd1, {2'b00, NIB_LDUW}, 1'b1, 13'h1),
                       32'h0, 32'h0, 8'h00, FILL_RANDOM);
        queue_directed(make_insn(OP_MEM, 5'd1, {2'b10, NIB_HOLE}, 1'b1, 13'h1),
                       32'h0, 32'h0, 8'h00, FILL_RANDOM);
        queue_directed(make_insn(OP_MEM, 5'd1, {2'b00, NIB_BAD}, 1'b1, 13'h1),
                       32'h0, 32'h0, 8'h00, FILL_RANDOM);
        queue_directed(make_insn(OP_MEM, 5'd1, {2'b01, NIB_LDUW}, 1'b1, 13'h1),
                       32'h0, 32'h0, 8'h00, FILL_RANDOM);
        // address equal to the reset limit faults
        queue_directed(make_insn(OP_MEM, 5'd1, {2'b00, NIB_LDUW}, 1'b0, 13'h0),
                       32'hFFFF_FFFF, 32'h0, 8'h00, FILL_RANDOM);
        drain();

        // Random phases, each under its own limit and sender idling
        for (int p = 0; p < 5; p++) begin
            lim = phase_limit[p];
            write_limit(lim);
            @(posedge clk);
            sender_idle_pct = phase_idle[p];
            for (int n = 0; n < phase_count[p]; n++) queue_access(random_access(lim));
            drain();
        end

        if (mismatch_count == 0 && expected_fixups.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
